// ===== rtl/core/lkv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lkv_pkg;

    // Widths that the interface fixes, and the capacity reset value.
    parameter int CAP_BITS  = 5;
    parameter int OUT_BITS  = 32;
    parameter int CAP_RESET = 16;

    // Operation codes.
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic match;
        logic apply;
        logic deliver;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic op_put;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== rtl/core/lkv_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface lkv_req_if #(
    parameter int KEY_BITS   = 16,
    parameter int VALUE_BITS = 32
);
    logic                         valid;
    logic                         ready;
    logic                         operation;
    logic        [KEY_BITS-1:0]   key;
    logic signed [VALUE_BITS-1:0] value;

    modport source (output valid, output operation, output key, output value, input ready);
    modport sink   (input valid, input operation, input key, input value, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lkv_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface lkv_rsp_if;
    import lkv_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       hit;
    logic signed [OUT_BITS-1:0] read_value;

    modport source (output valid, output hit, output read_value, input ready);
    modport sink   (input valid, input hit, input read_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lru_key_value_cache.sv =====
// Fully associative key-value cache with least-recently-used replacement.
// Requests arrive on i_req as words of operation, key and value; a get
// (operation 0) returns one word on o_rsp with hit and read_value, which is
// zero on a miss; a put (operation 1) updates or inserts and returns nothing.
// Both channels transfer a word when valid and ready are high at a clock edge.
// The user must write the capacity register (i_cfg_we, i_cfg_wdata) only
// while the block is idle; the block does not enforce this. A write empties
// the cache. Capacity zero acts as one; values above ENTRIES act as ENTRIES.
// A request is handled in steps of a controller: accept, associative match
// over all entries, update of keys and values for a put and of recency
// ranks for a put or a hit, and for a get a read of the value memory into the
// output register. A put passes the states idle, match and apply; a get
// also passes deliver, which waits until the output register is free.
// When the receiver stalls, the response waits in the output register and the
// next request is still accepted; a further get then holds until that register
// is free. Reset empties the cache, sets capacity to 16 and drops any
// pending response.
`timescale 1ns / 1ps
`default_nettype none

module lru_key_value_cache #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 16,
    parameter int VALUE_BITS = 32
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    lkv_req_if.sink                            i_req,
    lkv_rsp_if.source                          o_rsp,
    input  wire                                i_cfg_we,
    input  wire       [lkv_pkg::CAP_BITS-1:0]  i_cfg_wdata
);
    import lkv_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    lkv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .o_cmd      (w_cmd),
        .i_status   (w_status)
    );

    lkv_datapath #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_operation  (i_req.operation),
        .i_key        (i_req.key),
        .i_value      (i_req.value),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_out_ready  (o_rsp.ready),
        .o_out_valid  (o_rsp.valid),
        .o_hit        (o_rsp.hit),
        .o_read_value (o_rsp.read_value)
    );

endmodule

`default_nettype wire

// ===== rtl/core/lkv_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lkv_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    output lkv_pkg::t_dp_cmd    o_cmd,
    input  lkv_pkg::t_dp_status i_status
);
    import lkv_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_APPLY,
        S_DELIVER
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_MATCH;
                end
            end
            S_MATCH: begin
                o_cmd.match = 1'b1;
                n_state     = S_APPLY;
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state     = i_status.op_put ? S_IDLE : S_DELIVER;
            end
            S_DELIVER: begin
                o_cmd.deliver = i_status.out_free;
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/lkv_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lkv_datapath #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 16,
    parameter int VALUE_BITS = 32
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  lkv_pkg::t_dp_cmd                    i_cmd,
    output lkv_pkg::t_dp_status                 o_status,
    input  wire                                 i_operation,
    input  wire        [KEY_BITS-1:0]           i_key,
    input  wire signed [VALUE_BITS-1:0]         i_value,
    input  wire                                 i_cfg_we,
    input  wire        [lkv_pkg::CAP_BITS-1:0]  i_cfg_wdata,
    input  wire                                 i_out_ready,
    output logic                                o_out_valid,
    output logic                                o_hit,
    output logic signed [lkv_pkg::OUT_BITS-1:0] o_read_value
);
    import lkv_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CAP_BITS) ? CNT_W : CAP_BITS;

    // Valid entries always occupy slots 0 to used count minus one, and their
    // ranks form a permutation of 0 to used count minus one.
    logic [CNT_W-1:0]      r_used;
    logic [CAP_BITS-1:0]   r_cap;
    logic [KEY_BITS-1:0]   r_keys [ENTRIES];
    logic [IDX_W-1:0]      r_rank [ENTRIES];
    logic [VALUE_BITS-1:0] r_mem  [ENTRIES];
    logic [VALUE_BITS-1:0] r_rd_data;

    logic                  r_op;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;
    logic                  r_hit;
    logic                  r_fresh;
    logic [IDX_W-1:0]      r_slot;
    logic [IDX_W-1:0]      r_old_rank;

    logic                  r_out_valid;
    logic                  r_out_hit;
    logic [OUT_BITS-1:0]   r_out_data;

    logic [ENTRIES-1:0]    w_valid;
    logic [ENTRIES-1:0]    w_match;
    logic [ENTRIES-1:0]    w_lru;
    logic [IDX_W-1:0]      w_match_idx;
    logic [IDX_W-1:0]      w_match_rank;
    logic [IDX_W-1:0]      w_lru_idx;
    logic [CNT_W-1:0]      w_used_m1;
    logic [CMP_W-1:0]      w_eff_cap;
    logic                  w_full;
    logic                  w_any_hit;
    logic                  w_touch;
    logic [OUT_BITS+VALUE_BITS-1:0] w_ext;

    assign w_used_m1 = r_used - CNT_W'(1);

    always_comb begin
        if (r_cap == '0) begin
            w_eff_cap = CMP_W'(1);
        end else if (CMP_W'(r_cap) > CMP_W'(ENTRIES)) begin
            w_eff_cap = CMP_W'(ENTRIES);
        end else begin
            w_eff_cap = CMP_W'(r_cap);
        end
    end

    assign w_full = CMP_W'(r_used) >= w_eff_cap;

    always_comb begin
        w_match_idx  = '0;
        w_match_rank = '0;
        w_lru_idx    = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            w_valid[i] = CNT_W'(i) < r_used;
            w_match[i] = w_valid[i] && (r_keys[i] == r_key);
            w_lru[i]   = w_valid[i] && (r_rank[i] == w_used_m1[IDX_W-1:0]);
            w_match_idx  = w_match_idx  | (w_match[i] ? IDX_W'(i) : '0);
            w_match_rank = w_match_rank | (w_match[i] ? r_rank[i] : '0);
            w_lru_idx    = w_lru_idx    | (w_lru[i]   ? IDX_W'(i) : '0);
        end
    end

    assign w_any_hit = |w_match;
    assign w_touch   = i_cmd.apply && ((r_op == OP_PUT) || r_hit);

    // Request and lookup registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_operation;
            r_key   <= i_key;
            r_value <= i_value;
        end
        if (i_cmd.match) begin
            r_hit   <= w_any_hit;
            r_fresh <= !w_any_hit && !w_full;
            if (w_any_hit) begin
                r_slot     <= w_match_idx;
                r_old_rank <= w_match_rank;
            end else if (w_full) begin
                r_slot     <= w_lru_idx;
                r_old_rank <= w_used_m1[IDX_W-1:0];
            end else begin
                r_slot     <= r_used[IDX_W-1:0];
                r_old_rank <= r_used[IDX_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_cap  <= CAP_BITS'(CAP_RESET);
        end else if (i_cfg_we) begin
            r_used <= '0;
            r_cap  <= i_cfg_wdata;
        end else if (i_cmd.apply && (r_op == OP_PUT) && r_fresh) begin
            r_used <= r_used + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply && (r_op == OP_PUT) && !r_hit) begin
            r_keys[r_slot] <= r_key;
        end
    end

    // The touched slot becomes most recent; valid entries more recent age by one.
    always_ff @(posedge i_clk) begin
        if (w_touch) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (IDX_W'(i) == r_slot) begin
                    r_rank[i] <= '0;
                end else if (w_valid[i] && (r_rank[i] < r_old_rank)) begin
                    r_rank[i] <= r_rank[i] + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply && (r_op == OP_PUT)) begin
            r_mem[r_slot] <= r_value;
        end
        r_rd_data <= r_mem[r_slot];
    end

    assign w_ext = {{OUT_BITS{1'b0}}, r_rd_data};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.deliver) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.deliver) begin
            r_out_hit  <= r_hit;
            r_out_data <= r_hit ? w_ext[OUT_BITS-1:0] : '0;
        end
    end

    assign o_status.op_put   = (r_op == OP_PUT);
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_hit        = r_out_hit;
    assign o_read_value = r_out_data;

endmodule

`default_nettype wire
